[rtl/alat_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alat_pkg
// Shared types and constants for the alias address table.
// ----------------------------------------------------------------------------
package alat_pkg;

  localparam int DEFAULT_TABLE_DEPTH = 64;

  typedef enum logic [2:0] {
    CMD_INSERT      = 3'd0,
    CMD_LOOKUP      = 3'd1,
    CMD_UPDATE      = 3'd2,
    CMD_DELETE      = 3'd3,
    CMD_LIST_PREFIX = 3'd4,
    CMD_LIST_ALL    = 3'd5
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_ALIAS_EXISTS = 3'd1,
    ST_ADDR_EXISTS  = 3'd2,
    ST_NOT_FOUND    = 3'd3,
    ST_FULL         = 3'd4
  } status_t;

  // one table row, same layout as the stream data word
  typedef struct packed {
    logic [31:0] address;
    logic [63:0] alias_lo;
    logic [15:0] alias_hi;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // compare unit results
  typedef struct packed {
    logic alias_eq;
    logic addr_eq;
    logic prefix_eq;
  } cmp_t;

endpackage

[rtl/alat_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alat_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module alat_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/alat_cmp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alat_cmp
// Shared compare unit: one stored row against the command key.
// ----------------------------------------------------------------------------
module alat_cmp
  import alat_pkg::*;
(
  input  entry_t row,
  input  entry_t key,
  output cmp_t   res
);

  always_comb begin
    res.alias_eq  = (row.alias_hi == key.alias_hi) && (row.alias_lo == key.alias_lo);
    res.addr_eq   = (row.address == key.address);
    res.prefix_eq = (row.address[31:16] == key.address[31:16]);
  end

endmodule

[rtl/alias_address_table.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alias_address_table
// Insertion-ordered alias / IPv4 table, rows scanned one per cycle through
// a shared compare unit and one simple dual-port RAM, unless a list result waits.
// ----------------------------------------------------------------------------
// a one-result command reads every used row (one RAM read per row) before
//   it gives its result
// delete then moves each row above the deleted one down before its result
// lists give one result per match (not-found if none) and stall the scan while the output waits
// one command at a time, s_tready high only when idle, again in the cycle after the last result
// reset clears the row count and control; rows are undefined until written
// ----------------------------------------------------------------------------
module alias_address_table
  import alat_pkg::*;
#(
  parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [111:0] s_tdata,   // alias_hi, alias_lo, ip_address
  input  logic [2:0]   s_tuser,   // command
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [119:0] m_tdata,   // out_alias_hi, out_alias_lo, out_address, entry_count
  output logic [2:0]   m_tuser,   // status
  output logic         m_tlast
);

  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_SHIFT  = 4'b0100,
    S_FINISH = 4'b1000
  } state_t;

  state_t state, state_next;

  cmd_t             cmd;
  entry_t           key;
  logic [CNT_W-1:0] used;
  logic [CNT_W-1:0] rd_idx;
  logic             rd_v;
  logic [IDX_W-1:0] rd_i;
  logic             alias_hit;
  logic [IDX_W-1:0] alias_idx;
  entry_t           alias_data;
  logic             addr_hit;
  entry_t           addr_data;
  logic             pend_v;
  entry_t           pend_data;
  logic             shifted;

  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  entry_t           ram_wdata;
  logic             ram_re;
  entry_t           ram_rdata;
  cmp_t             cmp;

  logic             is_list;
  logic             list_hit;
  logic             can_push;
  logic             scan_stall;
  logic             issue;
  logic             scan_done;
  logic             push;
  status_t          push_status;
  entry_t           push_data;
  logic [CNT_W-1:0] push_count;
  logic             push_last;
  logic             used_inc;
  logic             used_dec;
  logic             start_shift;
  logic             cmd_known;

  alat_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (rd_idx[IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  alat_cmp u_cmp (
    .row (ram_rdata),
    .key (key),
    .res (cmp)
  );

  assign s_tready   = (state == S_IDLE);
  assign cmd_known  = (s_tuser <= 3'(CMD_LIST_ALL));
  assign is_list    = (cmd == CMD_LIST_PREFIX) || (cmd == CMD_LIST_ALL);
  assign list_hit   = rd_v && is_list && ((cmd == CMD_LIST_ALL) || cmp.prefix_eq);
  assign can_push   = !m_tvalid || m_tready;
  assign scan_stall = (state == S_SCAN) && list_hit && pend_v && !can_push;
  assign issue      = (((state == S_SCAN) && !scan_stall) || (state == S_SHIFT))
                      && (rd_idx < used);
  assign ram_re     = issue;
  assign scan_done  = !rd_v && (rd_idx >= used);
  assign start_shift = (state == S_FINISH) && (cmd == CMD_DELETE) && alias_hit && !shifted;

  always_comb begin
    push        = 1'b0;
    push_status = ST_OK;
    push_data   = '0;
    push_count  = used;
    push_last   = 1'b1;
    ram_we      = 1'b0;
    ram_waddr   = rd_i - IDX_W'(1);
    ram_wdata   = ram_rdata;
    used_inc    = 1'b0;
    used_dec    = 1'b0;
    unique case (state)
      S_SCAN: begin
        if (list_hit && pend_v && can_push) begin
          push      = 1'b1;
          push_data = pend_data;
          push_last = 1'b0;
        end
      end
      S_SHIFT: begin
        ram_we = rd_v;
      end
      S_FINISH: begin
        if (can_push) begin
          unique case (cmd)
            CMD_INSERT: begin
              push = 1'b1;
              if (alias_hit) begin
                push_status = ST_ALIAS_EXISTS;
                push_data   = alias_data;
              end else if (addr_hit) begin
                push_status = ST_ADDR_EXISTS;
                push_data   = addr_data;
              end else if (used == CNT_W'(TABLE_DEPTH)) begin
                push_status = ST_FULL;
              end else begin
                ram_we     = 1'b1;
                ram_waddr  = used[IDX_W-1:0];
                ram_wdata  = key;
                push_data  = key;
                push_count = used + CNT_W'(1);
                used_inc   = 1'b1;
              end
            end
            CMD_LOOKUP: begin
              push = 1'b1;
              if (alias_hit) begin
                push_data = alias_data;
              end else begin
                push_status = ST_NOT_FOUND;
              end
            end
            CMD_UPDATE: begin
              push = 1'b1;
              if (!alias_hit) begin
                push_status = ST_NOT_FOUND;
              end else if (addr_hit) begin
                push_status = ST_ADDR_EXISTS;
                push_data   = addr_data;
              end else begin
                push_data         = alias_data;
                push_data.address = key.address;
                ram_we            = 1'b1;
                ram_waddr         = alias_idx;
                ram_wdata         = push_data;
              end
            end
            CMD_DELETE: begin
              if (!alias_hit) begin
                push        = 1'b1;
                push_status = ST_NOT_FOUND;
              end else if (shifted) begin
                push       = 1'b1;
                push_data  = alias_data;
                push_count = used - CNT_W'(1);
                used_dec   = 1'b1;
              end
            end
            CMD_LIST_PREFIX, CMD_LIST_ALL: begin
              push = 1'b1;
              if (pend_v) begin
                push_data = pend_data;
              end else begin
                push_status = ST_NOT_FOUND;
              end
            end
            default: ;
          endcase
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid && cmd_known) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_done) begin
          state_next = S_FINISH;
        end
      end
      S_SHIFT: begin
        if (scan_done) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (start_shift) begin
          state_next = S_SHIFT;
        end else if (can_push) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      used      <= '0;
      rd_v      <= 1'b0;
      alias_hit <= 1'b0;
      addr_hit  <= 1'b0;
      pend_v    <= 1'b0;
      shifted   <= 1'b0;
      m_tvalid  <= 1'b0;
    end else begin
      state <= state_next;
      if (push) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          rd_v      <= 1'b0;
          alias_hit <= 1'b0;
          addr_hit  <= 1'b0;
          pend_v    <= 1'b0;
          shifted   <= 1'b0;
        end
        S_SCAN: begin
          if (!scan_stall) begin
            rd_v <= issue;
            if (rd_v && cmp.alias_eq) begin
              alias_hit <= 1'b1;
            end
            if (rd_v && cmp.addr_eq) begin
              addr_hit <= 1'b1;
            end
            if (list_hit) begin
              pend_v <= 1'b1;
            end
          end
        end
        S_SHIFT: begin
          rd_v <= issue;
          if (scan_done) begin
            shifted <= 1'b1;
          end
        end
        S_FINISH: begin
          rd_v <= 1'b0;
          if (used_inc) begin
            used <= used + CNT_W'(1);
          end else if (used_dec) begin
            used <= used - CNT_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (push) begin
      m_tdata <= {1'b0, 7'(push_count), push_data};
      m_tuser <= push_status;
      m_tlast <= push_last;
    end
    unique case (state)
      S_IDLE: begin
        cmd    <= cmd_t'(s_tuser);
        key    <= entry_t'(s_tdata);
        rd_idx <= '0;
      end
      S_SCAN: begin
        if (!scan_stall) begin
          rd_i <= rd_idx[IDX_W-1:0];
          if (issue) begin
            rd_idx <= rd_idx + CNT_W'(1);
          end
          if (rd_v && cmp.alias_eq && !alias_hit) begin
            alias_idx  <= rd_i;
            alias_data <= ram_rdata;
          end
          if (rd_v && cmp.addr_eq && !addr_hit) begin
            addr_data <= ram_rdata;
          end
          if (list_hit) begin
            pend_data <= ram_rdata;
          end
        end
      end
      S_SHIFT: begin
        rd_i <= rd_idx[IDX_W-1:0];
        if (issue) begin
          rd_idx <= rd_idx + CNT_W'(1);
        end
      end
      S_FINISH: begin
        if (start_shift) begin
          rd_idx <= CNT_W'(alias_idx) + CNT_W'(1);
        end
      end
      default: ;
    endcase
  end

`ifndef NO_ASSERTIONS
  a_used_in_range: assert property (@(posedge clk) disable iff (rst)
    used <= CNT_W'(TABLE_DEPTH))
    else $error("row count beyond table depth");

  a_push_when_free: assert property (@(posedge clk) disable iff (rst)
    push |-> (!m_tvalid || m_tready))
    else $error("result overwrites a pending transaction");

  a_count_only_at_finish: assert property (@(posedge clk) disable iff (rst)
    (state != S_FINISH) |=> $stable(used))
    else $error("row count changed outside finish");

  a_scan_push_not_last: assert property (@(posedge clk) disable iff (rst)
    (push && (state == S_SCAN)) |-> !push_last)
    else $error("list result marked last before scan end");
`endif

endmodule
